// ----- sv/scme_pkg.sv -----
package scme_pkg;

  // Field widths
  localparam int VERTEX_W = 10;
  localparam int WEIGHT_W = 16;
  localparam int CUT_W    = 40;
  localparam int ACC_W    = 42;
  localparam int SIZE_W   = 10;
  localparam int COUNT_W  = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX        = 11'd2047;
  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 11'd2;

  // Running cut limits, one bit wider than the accumulator
  localparam logic signed [ACC_W:0] CUT_MAX_X = 43'sh0FF_FFFF_FFFF;
  localparam logic signed [ACC_W:0] CUT_MIN_X = 43'sh600_0000_0000;

  // Membership bitmap rows
  localparam int ROW_W     = 32;
  localparam int ROW_BIT_W = 5;

  // Queues
  localparam int MID_DEPTH = 4;
  localparam int MID_CW    = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH = 2;
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  // Configuration port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = '0;

  // Classified edge beat between front and back
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                has_edge;
    logic                in_set;
    logic                close;
    logic                sdone;
  } mid_t;

  // Result beat
  typedef struct packed {
    logic [CUT_W-1:0]  best_cut;
    logic [SIZE_W-1:0] best_size;
    logic              best_side;
    logic              cut_saturated;
  } res_t;

endpackage

// ----- sv/scme_fifo.sv -----
module scme_fifo #(
  parameter type T     = logic,
  parameter int  Depth = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  T                             data_i,
  input  logic                         pop_i,
  output T                             data_o,
  output logic                         empty_o,
  output logic [$clog2(Depth+1)-1:0]   count_o
);

  localparam int PW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  T              mem_q [Depth];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(Depth - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(Depth - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- sv/scme_front.sv -----
module scme_front import scme_pkg::*; #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [VERTEX_W-1:0] vertex_i,
  input  logic [VERTEX_W-1:0] neighbor_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  input  logic                has_edge_i,
  input  logic                vertex_done_i,
  input  logic                sweep_done_i,
  input  logic [MID_CW-1:0]   mid_cnt_i,
  output logic                mid_push_o,
  output mid_t                mid_o
);

  // only indices below both the field range and MAX_VERTICES are stored
  localparam int unsigned NV = (MAX_VERTICES < (1 << VERTEX_W)) ? MAX_VERTICES
                                                                 : (1 << VERTEX_W);
  localparam int ROWS_USED = (NV + ROW_W - 1) / ROW_W;
  localparam int ROW_AW    = (ROWS_USED > 1) ? $clog2(ROWS_USED) : 1;
  localparam int ROWS      = 1 << ROW_AW;

  logic [ROW_W-1:0]     mem_q [ROWS];
  logic [ROWS-1:0]      row_vld_q;

  logic                 accept;
  logic                 wr_en;
  logic                 v_in, u_in;
  logic [ROW_AW-1:0]    v_row, u_row;
  logic [ROW_BIT_W-1:0] v_bit, u_bit;

  logic                 f1_vld_q;
  logic [ROW_W-1:0]     rd_row_q;
  logic                 rd_vld_q;
  logic [ROW_BIT_W-1:0] u_bit_q;
  logic                 u_in_q;
  logic                 self_q;
  logic [WEIGHT_W-1:0]  weight_q;
  logic                 has_edge_q;
  logic                 close_q;
  logic                 sdone_q;

  // room check counts the beat already in the lookup stage
  assign full_o = ({1'b0, mid_cnt_i} + (MID_CW+1)'(f1_vld_q)) >= (MID_CW+1)'(MID_DEPTH);
  assign accept = push_i && !full_o;

  assign v_in  = (32'(vertex_i) < NV);
  assign u_in  = (32'(neighbor_i) < NV);
  assign v_row = vertex_i[ROW_BIT_W +: ROW_AW];
  assign u_row = neighbor_i[ROW_BIT_W +: ROW_AW];
  assign v_bit = vertex_i[ROW_BIT_W-1:0];
  assign u_bit = neighbor_i[ROW_BIT_W-1:0];

  // the sweep-end beat is not marked, the map is dropped after it
  assign wr_en = accept && !sweep_done_i && v_in;

  // row valid bits: a row not yet written this sweep reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (accept && sweep_done_i) begin
      row_vld_q <= '0;
    end else if (wr_en) begin
      row_vld_q[v_row] <= 1'b1;
    end
  end

  // bitmap: bit-enable write of the vertex, registered read of the neighbour row
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      for (int b = 0; b < ROW_W; b++) begin
        if (!row_vld_q[v_row] || (ROW_BIT_W'(b) == v_bit)) begin
          mem_q[v_row][b] <= (ROW_BIT_W'(b) == v_bit);
        end
      end
    end
    rd_row_q <= mem_q[u_row];
  end

  // lookup stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else begin
      f1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_vld_q   <= row_vld_q[u_row];
      u_bit_q    <= u_bit;
      u_in_q     <= u_in;
      self_q     <= (neighbor_i == vertex_i);
      weight_q   <= weight_i;
      has_edge_q <= has_edge_i;
      close_q    <= vertex_done_i || sweep_done_i;
      sdone_q    <= sweep_done_i;
    end
  end

  // classify: a self-loop counts as inside
  assign mid_push_o      = f1_vld_q;
  assign mid_o.weight    = weight_q;
  assign mid_o.has_edge  = has_edge_q;
  assign mid_o.in_set    = u_in_q && (self_q || (rd_vld_q && rd_row_q[u_bit_q]));
  assign mid_o.close     = close_q;
  assign mid_o.sdone     = sdone_q;

endmodule

// ----- sv/scme_back.sv -----
module scme_back import scme_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [COUNT_W-1:0] vertex_count_i,
  input  logic               mid_empty_i,
  input  mid_t               mid_i,
  output logic               mid_pop_o,
  input  logic [OUT_CW-1:0]  out_cnt_i,
  output logic               res_push_o,
  output res_t               res_o
);

  localparam int PW = CUT_W + SIZE_W;

  typedef struct packed {
    logic              live;
    logic              score;
    logic [CUT_W-1:0]  cut;
    logic [SIZE_W-1:0] den;
    logic              side;
    logic              sdone;
    logic              sat;
  } score_t;

  logic signed [ACC_W-1:0] rc_q, rc_d;
  logic [COUNT_W-1:0]      cnt_q, cnt_d, cnt_inc;
  logic                    sat_q, sat_d, sat_now, sat_hit;
  score_t                  s_q, s_d;

  logic signed [ACC_W:0]   acc_x, w_x, sum_x;
  logic [ACC_W-1:0]        cut_e, cut_c;
  logic [COUNT_W-1:0]      half, den_full;
  logic                    room;

  logic                    best_vld_q;
  logic [CUT_W-1:0]        best_cut_q;
  logic [SIZE_W-1:0]       best_size_q;
  logic                    best_side_q;
  logic [PW-1:0]           p_new, p_old;
  logic                    win;
  logic [CUT_W-1:0]        nb_cut;
  logic [SIZE_W-1:0]       nb_size;
  logic                    nb_side;

  // a sweep-end beat waits until its result has a slot
  assign room = ({1'b0, out_cnt_i} + (OUT_CW+1)'(s_q.live & s_q.sdone))
                < (OUT_CW+1)'(OUT_DEPTH);
  assign mid_pop_o = !mid_empty_i && (!mid_i.sdone || room);

  // accumulate with saturation at both ends
  assign acc_x = $signed({rc_q[ACC_W-1], rc_q});
  assign w_x   = $signed({{(ACC_W + 1 - WEIGHT_W){1'b0}}, mid_i.weight});

  always_comb begin
    sum_x   = acc_x;
    sat_hit = 1'b0;
    if (mid_i.has_edge) begin
      if (mid_i.in_set) begin
        sum_x = acc_x - w_x;
        if (sum_x < CUT_MIN_X) begin
          sum_x = CUT_MIN_X;
        end
      end else begin
        sum_x = acc_x + w_x;
        if (sum_x > CUT_MAX_X) begin
          sum_x   = CUT_MAX_X;
          sat_hit = 1'b1;
        end
      end
    end
  end

  assign cut_e   = sum_x[ACC_W-1:0];
  assign cut_c   = cut_e[ACC_W-1] ? '0 : cut_e;
  assign sat_now = sat_q | sat_hit;
  assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_W'(1);
  assign half    = vertex_count_i >> 1;

  // vertex close: clamp, count, pick the smaller side
  always_comb begin
    s_d      = '0;
    s_d.live = mid_pop_o;
    den_full = (cnt_inc > half) ? vertex_count_i - cnt_inc : cnt_inc;
    s_d.side = (cnt_inc > half);
    s_d.den  = den_full[SIZE_W-1:0];
    s_d.cut  = cut_c[CUT_W-1:0];
    s_d.score = mid_i.close && (cnt_inc < vertex_count_i) && (den_full != '0);
    s_d.sdone = mid_i.sdone;
    s_d.sat   = sat_now;

    rc_d  = mid_i.close ? $signed(cut_c) : $signed(cut_e);
    cnt_d = mid_i.close ? cnt_inc : cnt_q;
    sat_d = sat_now;
    if (mid_i.sdone) begin
      rc_d  = '0;
      cnt_d = '0;
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q  <= '0;
      cnt_q <= '0;
      sat_q <= 1'b0;
      s_q   <= '0;
    end else begin
      if (mid_pop_o) begin
        rc_q  <= rc_d;
        cnt_q <= cnt_d;
        sat_q <= sat_d;
        s_q   <= s_d;
      end else begin
        s_q.live <= 1'b0;
      end
    end
  end

  // score by cross-multiplication, strictly smaller wins
  assign p_new = PW'(s_q.cut) * PW'(best_size_q);
  assign p_old = PW'(best_cut_q) * PW'(s_q.den);
  assign win   = s_q.live && s_q.score && (!best_vld_q || (p_new < p_old));

  assign nb_cut  = win ? s_q.cut  : best_cut_q;
  assign nb_size = win ? s_q.den  : best_size_q;
  assign nb_side = win ? s_q.side : best_side_q;

  // report on sweep end, then drop the best prefix
  assign res_push_o          = s_q.live && s_q.sdone;
  assign res_o.best_cut      = nb_cut;
  assign res_o.best_size     = nb_size;
  assign res_o.best_side     = nb_side;
  assign res_o.cut_saturated = s_q.sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_vld_q  <= 1'b0;
      best_cut_q  <= '0;
      best_size_q <= '0;
      best_side_q <= 1'b0;
    end else if (res_push_o) begin
      best_vld_q  <= 1'b0;
      best_cut_q  <= '0;
      best_size_q <= '0;
      best_side_q <= 1'b0;
    end else if (win) begin
      best_vld_q  <= 1'b1;
      best_cut_q  <= nb_cut;
      best_size_q <= nb_size;
      best_side_q <= nb_side;
    end
  end

endmodule

// ----- sv/sweep_cut_min_expansion.sv -----
// Minimum-expansion sweep cut over a streamed vertex ordering.
// Input queue: push/full. One beat per edge of the current vertex (or one
// edgeless beat), vertex_done_i on the last beat of a vertex, sweep_done_i on
// the last beat of the sweep. A beat is taken when push is high and full low.
// Result queue: empty/pop. One beat per sweep, on the sweep-end beat, with the
// best cut, its smaller-side size, which side that is, and the saturation flag.
// Throughput: one input beat per cycle while full is low. The front marks the
// bitmap with one row write and looks the neighbour up with one registered row
// read per cycle; the back adds one weight to the running cut per cycle unless
// a sweep-end beat waits for a result slot. A result passes the lookup stage,
// the front-to-back queue, the back's score register and the result queue.
// Reset: all sweep state clears at once (the bitmap through per-row valid
// bits, no clearing pass); vertex_count returns to 2. After each report the
// sweep state clears the same way, vertex_count is kept.
// Receiver stall: two result beats are held; a further sweep-end beat waits in
// the back, then the 4-beat queue between front and back fills and full rises.
// Configuration: APB register 0 (vertex_count) at address 0, written only idle by the user; not enforced.
module sweep_cut_min_expansion import scme_pkg::*; #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  // input beats
  input  logic                push,
  output logic                full,
  input  logic [VERTEX_W-1:0] vertex_i,
  input  logic [VERTEX_W-1:0] neighbor_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  input  logic                has_edge_i,
  input  logic                vertex_done_i,
  input  logic                sweep_done_i,
  // result beats
  output logic                empty,
  input  logic                pop,
  output logic [CUT_W-1:0]    best_cut_o,
  output logic [SIZE_W-1:0]   best_size_o,
  output logic                best_side_o,
  output logic                cut_saturated_o
);

  logic [COUNT_W-1:0] vertex_count_q;

  logic               mid_push, mid_pop, mid_empty;
  mid_t               mid_in, mid_out;
  logic [MID_CW-1:0]  mid_cnt;

  logic               res_push;
  res_t               res_in, res_out;
  logic [OUT_CW-1:0]  out_cnt;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_VERTEX_COUNT) ? PDATA_W'(vertex_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VERTEX_COUNT_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[PADDR_W-1:2] == REG_VERTEX_COUNT)) begin
      vertex_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  scme_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .vertex_i      (vertex_i),
    .neighbor_i    (neighbor_i),
    .weight_i      (weight_i),
    .has_edge_i    (has_edge_i),
    .vertex_done_i (vertex_done_i),
    .sweep_done_i  (sweep_done_i),
    .mid_cnt_i     (mid_cnt),
    .mid_push_o    (mid_push),
    .mid_o         (mid_in)
  );

  scme_fifo #(
    .T     (mid_t),
    .Depth (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty),
    .count_o (mid_cnt)
  );

  scme_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .vertex_count_i (vertex_count_q),
    .mid_empty_i    (mid_empty),
    .mid_i          (mid_out),
    .mid_pop_o      (mid_pop),
    .out_cnt_i      (out_cnt),
    .res_push_o     (res_push),
    .res_o          (res_in)
  );

  scme_fifo #(
    .T     (res_t),
    .Depth (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty),
    .count_o (out_cnt)
  );

  assign best_cut_o      = res_out.best_cut;
  assign best_size_o     = res_out.best_size;
  assign best_side_o     = res_out.best_side;
  assign cut_saturated_o = res_out.cut_saturated;

endmodule

// ----- sv/scme_checker.sv -----
module scme_checker import scme_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic                pready,
  input logic [PADDR_W-1:0]  paddr,
  input logic [PDATA_W-1:0]  pwdata,
  input logic [PDATA_W-1:0]  prdata,
  input logic                empty,
  input logic                pop,
  input logic [CUT_W-1:0]    best_cut_o,
  input logic [SIZE_W-1:0]   best_size_o,
  input logic                best_side_o,
  input logic                cut_saturated_o
);

  // a sweep with no scored prefix reports an all-zero best
  a_no_score_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (best_size_o == '0)) |-> ((best_cut_o == '0) && !best_side_o))
    else $error("result with zero size carries a cut or side");

  // a waiting result beat stays until popped
  a_beat_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result beat vanished without pop");

  // and does not change while it waits
  a_beat_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(best_cut_o) && $stable(best_size_o) &&
                          $stable(best_side_o) && $stable(cut_saturated_o)))
    else $error("stalled result beat changed");

  // vertex_count reads back what was written
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr[PADDR_W-1:2] == REG_VERTEX_COUNT))
    ##1 (psel && !pwrite && (paddr[PADDR_W-1:2] == REG_VERTEX_COUNT))
    |-> ((prdata[COUNT_W-1:0] == $past(pwdata[COUNT_W-1:0])) &&
         (prdata[PDATA_W-1:COUNT_W] == '0)))
    else $error("vertex_count readback mismatch");

endmodule

bind sweep_cut_min_expansion scme_checker u_checker (.*);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import scme_pkg::*;

  localparam int     NODE_LIMIT   = 1024;
  localparam int     RANDOM_BEATS = 1650;
  localparam int     QUIET_LIMIT  = 2000;
  localparam longint CUT_TOP      = 64'sh00FF_FFFF_FFFF;
  localparam longint CUT_FLOOR    = -(longint'(1) << 41);

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [VERTEX_W-1:0] neighbor;
    logic [WEIGHT_W-1:0] weight;
    logic                has_edge;
    logic                vertex_done;
    logic                sweep_done;
  } edge_beat_t;

  // Tracks the sweep set, the running cut and the best prefix so far;
  // queues one report per sweep end and matches reports against it.
  class sweep_tracker;
    bit [NODE_LIMIT-1:0] in_sweep;
    longint              cut_acc;
    bit [COUNT_W-1:0]    closed;
    bit                  have_best;
    bit [CUT_W-1:0]      best_cut;
    bit [SIZE_W-1:0]     best_size;
    bit                  best_side;
    bit                  saturated;
    bit [COUNT_W-1:0]    vertex_count;
    res_t                reports_due[$];
    int                  mismatches;
    int                  reports_seen;

    function new();
      vertex_count = VERTEX_COUNT_RST;
      restart();
    endfunction

    function void restart();
      in_sweep  = '0;
      cut_acc   = 0;
      closed    = '0;
      have_best = 1'b0;
      best_cut  = '0;
      best_size = '0;
      best_side = 1'b0;
      saturated = 1'b0;
    endfunction

    function void take_beat(edge_beat_t b);
      longint k, half, den, n;
      bit     side;
      res_t   r;
      n = longint'(vertex_count);
      in_sweep[b.vertex] = 1'b1;
      // self-loops count as inside, the vertex is already marked
      if (b.has_edge) begin
        if (in_sweep[b.neighbor]) begin
          cut_acc -= longint'(b.weight);
          if (cut_acc < CUT_FLOOR) cut_acc = CUT_FLOOR;
        end else begin
          cut_acc += longint'(b.weight);
          if (cut_acc > CUT_TOP) begin
            cut_acc   = CUT_TOP;
            saturated = 1'b1;
          end
        end
      end
      // vertex end: clamp, count the prefix, score it against the best
      if (b.vertex_done || b.sweep_done) begin
        if (cut_acc < 0) cut_acc = 0;
        if (closed != COUNT_MAX) closed++;
        k    = longint'(closed);
        half = n / 2;
        if (k > half) begin
          den  = n - k;
          side = 1'b1;
        end else begin
          den  = k;
          side = 1'b0;
        end
        if (k < n && den != 0 &&
            (!have_best || cut_acc * longint'(best_size) < longint'(best_cut) * den)) begin
          have_best = 1'b1;
          best_cut  = cut_acc[CUT_W-1:0];
          best_size = den[SIZE_W-1:0];
          best_side = side;
        end
      end
      // best registers sit at zero when nothing was scored
      if (b.sweep_done) begin
        r = {best_cut, best_size, best_side, saturated};
        reports_due.push_back(r);
        restart();
      end
    endfunction

    function void tally(string field, longint want, longint got);
      mismatches++;
      if (mismatches <= 10)
        $display("report %0d: %s expected %0d, got %0d", reports_seen, field, want, got);
    endfunction

    function void match_report(res_t got);
      res_t want;
      reports_seen++;
      if (reports_due.size() == 0) begin
        tally("report with none due, best_cut", 0, longint'(got.best_cut));
        return;
      end
      want = reports_due.pop_front();
      if (got.best_cut !== want.best_cut)
        tally("best_cut", want.best_cut, got.best_cut);
      if (got.best_size !== want.best_size)
        tally("best_size", want.best_size, got.best_size);
      if (got.best_side !== want.best_side)
        tally("best_side", want.best_side, got.best_side);
      if (got.cut_saturated !== want.cut_saturated)
        tally("cut_saturated", want.cut_saturated, got.cut_saturated);
    endfunction
  endclass

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               push    = 1'b0;
  logic               full;
  logic               empty;
  logic               pop     = 1'b0;
  edge_beat_t         beat_q  = '0;
  logic [CUT_W-1:0]   best_cut_o;
  logic [SIZE_W-1:0]  best_size_o;
  logic               best_side_o;
  logic               cut_saturated_o;
  res_t               report_r;

  sweep_tracker tracker = new();
  bit push_idle = 1'b0;
  bit pop_idle  = 1'b1;
  int items_sent;
  int sweeps_run;
  int settings_run;
  int quiet_cycles;

  assign report_r = {best_cut_o, best_size_o, best_side_o, cut_saturated_o};

  sweep_cut_min_expansion uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .push           (push),
    .full           (full),
    .vertex_i       (beat_q.vertex),
    .neighbor_i     (beat_q.neighbor),
    .weight_i       (beat_q.weight),
    .has_edge_i     (beat_q.has_edge),
    .vertex_done_i  (beat_q.vertex_done),
    .sweep_done_i   (beat_q.sweep_done),
    .empty          (empty),
    .pop            (pop),
    .best_cut_o     (best_cut_o),
    .best_size_o    (best_size_o),
    .best_side_o    (best_side_o),
    .cut_saturated_o(cut_saturated_o)
  );

  always #2 clk_i = ~clk_i;

  // beats taken on each side, seen with pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) tracker.take_beat(beat_q);
    if (rst_ni && pop && !empty) tracker.match_report(report_r);
  end

  // watchdog: too long without a beat on either side
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stall before each report
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = pop_idle ? $urandom_range(5) : 0;
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  function automatic edge_beat_t pack_beat(int v, int u, int w, bit e, bit vd, bit sd);
    edge_beat_t b;
    b.vertex      = v[VERTEX_W-1:0];
    b.neighbor    = u[VERTEX_W-1:0];
    b.weight      = w[WEIGHT_W-1:0];
    b.has_edge    = e;
    b.vertex_done = vd;
    b.sweep_done  = sd;
    return b;
  endfunction

  // push holds high across back-to-back beats
  task automatic send_beat(input edge_beat_t b);
    int gap;
    gap = push_idle ? $urandom_range(5) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push   <= 1'b1;
    beat_q <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
  endtask

  // hold off until every report is in and the pipeline has gone quiet
  task automatic settle();
    push <= 1'b0;
    while (tracker.reports_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_count(input int n);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_VERTEX_COUNT, 2'b00};
    pwdata  <= PDATA_W'(n);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.vertex_count = n[COUNT_W-1:0];
    settings_run++;
  endtask

  // well-formed sweep over a shuffled ordering; light keeps weights tiny so
  // that equal ratios turn up
  task automatic sweep(input int n, input int span, input bit light);
    int order[$];
    int pool, v, u, w, ne, j, t, pick;
    bit sd;
    pool = (n < 2) ? 2 : (n > NODE_LIMIT ? NODE_LIMIT : n);
    for (t = 0; t < pool; t++) order.push_back(t);
    for (t = pool - 1; t > 0; t--) begin
      j        = $urandom_range(t);
      v        = order[t];
      order[t] = order[j];
      order[j] = v;
    end
    for (t = 0; t < span; t++) begin
      v  = order[t % pool];
      ne = $urandom_range(3);
      sd = (t == span - 1);
      if (ne == 0) begin
        send_beat(pack_beat(v, $urandom_range(1023), $urandom_range(65535), 1'b0,
                            !(sd && $urandom_range(7) == 0), sd));
      end else begin
        for (j = 0; j < ne; j++) begin
          pick = $urandom_range(9);
          if (pick == 0) u = v;
          else if (pick == 1) u = $urandom_range(1023);
          else if (pick < 5) u = order[$urandom_range(t % pool)];
          else u = order[$urandom_range(pool - 1)];
          pick = $urandom_range(9);
          if (light) w = $urandom_range(1, 4);
          else if (pick == 0) w = 0;
          else if (pick == 1) w = 65535;
          else w = $urandom_range(65535);
          send_beat(pack_beat(v, u, w, 1'b1,
                              (j == ne - 1) && !(sd && $urandom_range(7) == 0),
                              sd && (j == ne - 1)));
        end
      end
    end
    sweeps_run++;
  endtask

  // stray beats: any flags, any ids
  task automatic noise(input int count);
    repeat (count)
      send_beat(pack_beat($urandom_range(1023), $urandom_range(1023), $urandom_range(65535),
                          $urandom_range(1), $urandom_range(1), $urandom_range(5) == 0));
  endtask

  initial begin
    int n, pick, span;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset vertex_count of 2
    send_beat(pack_beat(0, 1, 16'hFFFF, 1'b1, 1'b1, 1'b1));
    // self-loop drives the cut negative, then sweep end without vertex end
    send_beat(pack_beat(10'h3FF, 10'h3FF, 16'h8000, 1'b1, 1'b0, 1'b0));
    send_beat(pack_beat(10'h3FF, 0, 1, 1'b1, 1'b0, 1'b1));
    // edgeless beats; the second prefix reaches n and is not scored
    send_beat(pack_beat(10'h3FF, 10'h3FF, 16'hFFFF, 1'b0, 1'b1, 1'b0));
    send_beat(pack_beat(0, 0, 0, 1'b0, 1'b0, 1'b1));
    // no scored prefix at all
    settle();
    write_count(1);
    send_beat(pack_beat(5, 6, 300, 1'b1, 1'b1, 1'b1));
    settle();
    write_count(0);
    send_beat(pack_beat(7, 7, 1, 1'b1, 1'b0, 1'b1));
    // widest graph, neighbours inside and outside
    settle();
    write_count(1024);
    send_beat(pack_beat(0, 1, 16'hFFFF, 1'b1, 1'b0, 1'b0));
    send_beat(pack_beat(0, 512, 16'hFFFF, 1'b1, 1'b1, 1'b0));
    send_beat(pack_beat(1, 0, 16'hFFFF, 1'b1, 1'b1, 1'b0));
    send_beat(pack_beat(512, 1, 5, 1'b1, 1'b0, 1'b0));
    send_beat(pack_beat(512, 0, 0, 1'b1, 1'b1, 1'b1));
    // field maximum
    settle();
    write_count(2047);
    send_beat(pack_beat(10'h200, 10'h155, 16'h5555, 1'b1, 1'b1, 1'b0));
    send_beat(pack_beat(10'h155, 10'h2AA, 16'hAAAA, 1'b1, 1'b1, 1'b1));
    // complement side wins
    settle();
    write_count(3);
    send_beat(pack_beat(0, 1, 10, 1'b1, 1'b1, 1'b0));
    send_beat(pack_beat(1, 0, 10, 1'b1, 1'b0, 1'b0));
    send_beat(pack_beat(1, 2, 3, 1'b1, 1'b1, 1'b1));
    // equal ratios keep the earlier prefix
    settle();
    write_count(4);
    send_beat(pack_beat(0, 3, 4, 1'b1, 1'b1, 1'b0));
    send_beat(pack_beat(1, 2, 4, 1'b1, 1'b1, 1'b1));
    sweeps_run += 9;

    // random phases: new vertex_count, then a few sweeps
    items_sent = 0;
    while (items_sent < RANDOM_BEATS) begin
      pick = $urandom_range(99);
      if (pick < 70) n = $urandom_range(2, 16);
      else if (pick < 85) n = $urandom_range(17, 64);
      else begin
        case ($urandom_range(4))
          0:       n = 2;
          1:       n = 1024;
          2:       n = 2047;
          3:       n = $urandom_range(1);
          default: n = $urandom_range(65, 2047);
        endcase
      end
      settle();
      write_count(n);
      push_idle = $urandom_range(3) != 0;
      pop_idle  = $urandom_range(3) != 0;
      if ($urandom_range(5) == 0) noise($urandom_range(1, 6));
      repeat ($urandom_range(1, 4)) begin
        if (n >= 2 && n <= 64) span = ($urandom_range(3) == 0) ? $urandom_range(1, n - 1) : n - 1;
        else span = $urandom_range(1, 24);
        sweep(n, span, $urandom_range(2) == 0);
      end
    end

    // drain, then let the pipeline go quiet
    push <= 1'b0;
    while (tracker.reports_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d sweeps over %0d vertex_count settings, %0d random-phase beats",
             sweeps_run, settings_run, items_sent);
    $display("%0d reports checked, %0d mismatches, %0d reports outstanding",
             tracker.reports_seen, tracker.mismatches, tracker.reports_due.size());
    if (tracker.mismatches == 0 && tracker.reports_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
